// ===== hdl/dmskc_pkg.sv =====
// Shared types and constants for the direct-mapped string-key cache.
`default_nettype none
package dmskc_pkg;

   // starting value of the 64-bit FNV-1a style key hash
   localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;

   // closing-word action codes
   typedef enum logic [2:0] {
      ACT_LOOKUP = 3'd0,
      ACT_STORE  = 3'd1,
      ACT_PUT    = 3'd2,
      ACT_INVAL  = 3'd3,
      ACT_CLEAR  = 3'd4,
      ACT_GEN    = 3'd5
   } action_type;

   // one bucket entry as held in the entry RAM
   typedef struct packed {
      logic        valid;
      logic [63:0] epoch;
      logic [63:0] meta;
      logic [7:0]  len;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage
`default_nettype wire

// ===== hdl/dmskc_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none
module dmskc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

// ===== hdl/direct_mapped_string_key_cache_top.sv =====
// A character word is absorbed in the idle state; a closing word passes through the hash
// remainder steps (only when BUCKETS is not a power of two), the entry read, the action
// decode, the key walk (a compare on a lookup that stops at the first mismatch, a copy on
// an install) and the result stage. A result still waiting in the output register holds the closing word.
// Throughput: one word at a time; the key walk reads one character per cycle. After reset
// a clearing pass over all buckets invalidates every entry before the first word is taken.
`default_nettype none
module direct_mapped_string_key_cache_top #(
   parameter int BUCKETS = 1024,
   parameter int KEY_MAX = 256
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [135:0]  req_tdata,  // key_char, meta_in, gen_snapshot
   input  wire logic [2:0]    req_tuser,  // action
   input  wire logic          req_tlast,  // key_last
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic      [127:0]  rsp_tdata,  // meta_out, gen_value
   output logic      [0:0]    rsp_tuser   // hit
);
   import dmskc_pkg::*;

   localparam int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int IW      = $clog2(KEY_MAX);
   localparam int LW      = $clog2(KEY_MAX + 1);
   localparam int KDEPTH  = BUCKETS * (2 ** IW);
   localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
   // 2^32 mod BUCKETS folds the upper half onto the lower half
   localparam logic [15:0] FOLD_K = 16'((64'd1 << 32) % 64'(BUCKETS));
   // reciprocal for the final remainder of a value below 2^34
   localparam logic [33:0] RECIP  = 34'((64'd1 << 34) / 64'(BUCKETS));

   typedef enum logic [2:0] {
      ST_CLR, ST_IDLE, ST_MOD, ST_ENT, ST_DEC, ST_CMP, ST_COPY, ST_DONE
   } state_type;

   state_type     state_ff, state_in;
   logic [63:0]   hash_ff, hash_in;
   logic [LW-1:0] len_ff, len_in;
   logic [63:0]   epoch_ff, epoch_in;
   logic [63:0]   gen_ff, gen_in;
   logic [BW-1:0] bucket_ff, bucket_in;
   logic [BW-1:0] clr_ff, clr_in;
   logic [63:0]   mod_sh_ff, mod_sh_in;
   logic [1:0]    mod_cnt_ff, mod_cnt_in;
   logic [33:0]   quo_ff, quo_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic          chk_ff, chk_in;
   logic          cp_ff, cp_in;
   logic [IW-1:0] widx_ff, widx_in;
   action_type    act_ff, act_in;
   logic [63:0]   meta_ff, meta_in;
   logic [63:0]   snap_ff, snap_in;
   logic          res_hit_ff, res_hit_in;
   logic [63:0]   res_meta_ff, res_meta_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [127:0]  rsp_data_ff, rsp_data_in;
   logic          rsp_user_ff, rsp_user_in;

   // RAM ports
   logic                ent_we;
   entry_type           ent_wdata, ent_rd;
   logic [ENTRY_W-1:0]  ent_rd_raw;
   logic [BW-1:0]       ent_waddr;
   logic                kb_we;
   logic [7:0]          kb_rd;
   logic                kr_we;
   logic [7:0]          kr_rd;

   assign ent_rd = entry_type'(ent_rd_raw);

   // entry table: valid, epoch, metadata, stored length
   dmskc_ram #(.WIDTH(ENTRY_W), .DEPTH(BUCKETS)) u_ent_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ENTRY_W'(ent_wdata)),
      .raddr (bucket_ff),
      .rdata (ent_rd_raw)
   );

   // incoming key buffer
   dmskc_ram #(.WIDTH(8), .DEPTH(2 ** IW)) u_kbuf_ram (
      .clock (clock),
      .we    (kb_we),
      .waddr (len_ff[IW-1:0]),
      .wdata (req_tdata[7:0]),
      .raddr (cnt_ff[IW-1:0]),
      .rdata (kb_rd)
   );

   // stored key characters, one row per bucket
   dmskc_ram #(.WIDTH(8), .DEPTH(KDEPTH)) u_key_ram (
      .clock (clock),
      .we    (kr_we),
      .waddr ({bucket_ff, widx_ff}),
      .wdata (kb_rd),
      .raddr ({bucket_ff, cnt_ff[IW-1:0]}),
      .rdata (kr_rd)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // next-state logic
   always_comb begin
      logic [63:0]   hx;
      logic [LW-1:0] nlen;
      logic [47:0]   fold;
      logic [67:0]   qprod;
      logic [33:0]   rem34;
      logic          issue;
      logic          hdr_ok;
      state_in     = state_ff;
      hash_in      = hash_ff;
      len_in       = len_ff;
      epoch_in     = epoch_ff;
      gen_in       = gen_ff;
      bucket_in    = bucket_ff;
      clr_in       = clr_ff;
      mod_sh_in    = mod_sh_ff;
      mod_cnt_in   = mod_cnt_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      chk_in       = chk_ff;
      cp_in        = cp_ff;
      widx_in      = widx_ff;
      act_in       = act_ff;
      meta_in      = meta_ff;
      snap_in      = snap_ff;
      res_hit_in   = res_hit_ff;
      res_meta_in  = res_meta_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      ent_we       = 1'b0;
      ent_waddr    = bucket_ff;
      ent_wdata    = '0;
      kb_we        = 1'b0;
      kr_we        = 1'b0;

      hx     = hash_ff ^ {56'd0, req_tdata[7:0]};
      nlen   = (len_ff < LW'(KEY_MAX - 1)) ? len_ff : LW'(KEY_MAX - 1);
      fold   = {16'd0, mod_sh_ff[63:32]} * {32'd0, FOLD_K};
      qprod  = {34'd0, mod_sh_ff[33:0]} * {34'd0, RECIP};
      rem34  = mod_sh_ff[33:0] - quo_ff * 34'(BUCKETS);
      issue  = 1'b0;
      hdr_ok = ent_rd.valid && (ent_rd.epoch == epoch_ff) && (len_ff < LW'(KEY_MAX))
               && (9'(ent_rd.len) == 9'(len_ff));

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         // clearing pass over all buckets
         ST_CLR: begin
            ent_we    = 1'b1;
            ent_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == BW'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         // take character words and the closing word
         ST_IDLE: begin
            if (req_tvalid) begin
               if (!req_tlast) begin
                  if (req_tdata[7:0] != 8'd0) begin
                     hash_in = (hx << 40) + (hx << 8) + (hx << 7) + (hx << 5)
                               + (hx << 4) + (hx << 1) + hx;
                     kb_we   = (len_ff < LW'(KEY_MAX - 1));
                     if (len_ff < LW'(KEY_MAX)) begin
                        len_in = len_ff + 1'b1;
                     end
                  end
               end else begin
                  act_in     = action_type'(req_tuser);
                  meta_in    = req_tdata[71:8];
                  snap_in    = req_tdata[135:72];
                  res_hit_in = 1'b0;
                  res_meta_in = '0;
                  if (IS_POW2) begin
                     bucket_in = hash_ff[BW-1:0];
                     state_in  = ST_ENT;
                  end else begin
                     mod_sh_in  = hash_ff;
                     mod_cnt_in = '0;
                     state_in   = ST_MOD;
                  end
               end
            end
         end
         // hash remainder: two folds, reciprocal quotient, one correction
         ST_MOD: begin
            mod_cnt_in = mod_cnt_ff + 1'b1;
            unique case (mod_cnt_ff)
               2'd0, 2'd1: begin
                  mod_sh_in = 64'(fold) + {32'd0, mod_sh_ff[31:0]};
               end
               2'd2: begin
                  quo_in = qprod[67:34];
               end
               default: begin
                  bucket_in = (rem34 >= 34'(BUCKETS)) ? BW'(rem34 - 34'(BUCKETS))
                                                      : BW'(rem34);
                  state_in  = ST_ENT;
               end
            endcase
         end
         // entry read in flight
         ST_ENT: begin
            state_in = ST_DEC;
         end
         // apply the action to the entry
         ST_DEC: begin
            cnt_in   = '0;
            chk_in   = 1'b0;
            cp_in    = 1'b0;
            state_in = ST_DONE;
            unique case (act_ff)
               ACT_LOOKUP: begin
                  if (hdr_ok) begin
                     if (len_ff == '0) begin
                        res_hit_in  = 1'b1;
                        res_meta_in = ent_rd.meta;
                     end else begin
                        state_in = ST_CMP;
                     end
                  end
               end
               ACT_STORE, ACT_PUT: begin
                  if (act_ff == ACT_PUT || gen_ff == snap_ff) begin
                     ent_we          = 1'b1;
                     ent_wdata.valid = 1'b1;
                     ent_wdata.epoch = epoch_ff;
                     ent_wdata.meta  = meta_ff;
                     ent_wdata.len   = 8'(nlen);
                     state_in        = ST_COPY;
                  end
                  if (act_ff == ACT_PUT) begin
                     gen_in = gen_ff + 1'b1;
                  end
               end
               ACT_INVAL: begin
                  ent_we = 1'b1;
                  gen_in = gen_ff + 1'b1;
               end
               ACT_CLEAR: begin
                  epoch_in = epoch_ff + 1'b1;
                  gen_in   = gen_ff + 1'b1;
               end
               default: begin
               end
            endcase
         end
         // walk the key, one character per cycle
         ST_CMP: begin
            issue = (cnt_ff < len_ff);
            if (chk_ff && (kb_rd != kr_rd)) begin
               state_in = ST_DONE;
            end else if (!issue && !chk_ff) begin
               res_hit_in  = 1'b1;
               res_meta_in = ent_rd.meta;
               state_in    = ST_DONE;
            end else begin
               chk_in = issue;
               if (issue) begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         // copy the buffered key into the bucket row
         ST_COPY: begin
            issue   = (cnt_ff < nlen);
            kr_we   = cp_ff;
            widx_in = cnt_ff[IW-1:0];
            cp_in   = issue;
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end else if (!cp_ff) begin
               state_in = ST_DONE;
            end
         end
         // hand the result to the output register, rearm the key
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_hit_ff;
               rsp_data_in  = {gen_ff, res_meta_ff};
               len_in       = '0;
               hash_in      = FNV_BASIS;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         hash_ff      <= FNV_BASIS;
         len_ff       <= '0;
         epoch_ff     <= '0;
         gen_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         len_ff       <= len_in;
         epoch_ff     <= epoch_in;
         gen_ff       <= gen_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bucket_ff   <= bucket_in;
      mod_sh_ff   <= mod_sh_in;
      mod_cnt_ff  <= mod_cnt_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      chk_ff      <= chk_in;
      cp_ff       <= cp_in;
      widx_ff     <= widx_in;
      act_ff      <= act_in;
      meta_ff     <= meta_in;
      snap_ff     <= snap_in;
      res_hit_ff  <= res_hit_in;
      res_meta_ff <= res_meta_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // a closing word blocks further input until its result is loaded
   a_close_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input taken while a closing word is in progress");

   // key length saturates at KEY_MAX
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(KEY_MAX))
      else $error("key length beyond saturation");

   // a result appears only out of the result stage
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the result stage");

   // no result during the clearing pass
   a_clr_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLR) |-> !rsp_valid_ff)
      else $error("result during clearing pass");

endmodule
`default_nettype wire
